// ----- src/imm_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// imm_pkg
// Shared types, register indexes and helpers of the integer matrix multiply.
// ----------------------------------------------------------------------------
package imm_pkg;

    localparam int DATA_W = 32;   // element and product width
    localparam int DIM_W  = 4;    // width of a dimension register
    localparam int IDX_W  = 3;    // width of a row or column index
    localparam int CNT_W  = 8;    // width of the load counter

    // Configuration register indexes
    localparam logic [1:0] REG_ROWS_A    = 2'd0;
    localparam logic [1:0] REG_INNER_DIM = 2'd1;
    localparam logic [1:0] REG_COLS_B    = 2'd2;

    // Tag that travels with one multiply-accumulate through the datapath
    typedef struct packed {
        logic             first;      // first term of an inner product
        logic             last_term;  // last term of an inner product
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic             final_elem; // last product element of the run
    } mac_tag_t;

    // Command from the controller to the datapath
    typedef struct packed {
        logic     wr_a;   // write the request element into the A store
        logic     wr_b;   // write the request element into the B store
        logic     issue;  // read one A/B pair and start a MAC
        mac_tag_t tag;
    } imm_cmd_t;

    // Clamp a dimension register to 1..maxd
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] maxd);
        logic [DIM_W-1:0] res;
        begin
            if (v == '0) begin
                res = {{(DIM_W-1){1'b0}}, 1'b1};
            end else if (v > maxd) begin
                res = maxd;
            end else begin
                res = v;
            end
            return res;
        end
    endfunction

endpackage
`default_nettype wire

// ----- src/imm_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// imm_datapath
// Matrix stores, multiply-accumulate pipeline and output register.
// ----------------------------------------------------------------------------
module imm_datapath #(
    parameter int MAX_DIM = 8,
    parameter int AW      = 6
) (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  imm_pkg::imm_cmd_t             cmd,
    input  wire [AW-1:0]                  wr_addr,
    input  wire [AW-1:0]                  rd_a_addr,
    input  wire [AW-1:0]                  rd_b_addr,
    input  wire signed [imm_pkg::DATA_W-1:0] wr_data,
    output logic                          pipe_en,
    output logic                          m_valid,
    input  wire                           m_ready,
    output logic signed [imm_pkg::DATA_W-1:0] m_product_value,
    output logic [imm_pkg::IDX_W-1:0]     m_row_index,
    output logic [imm_pkg::IDX_W-1:0]     m_col_index,
    output logic                          m_last_result
);
    import imm_pkg::*;

    localparam int DEPTH = MAX_DIM * MAX_DIM;

    logic [DATA_W-1:0] mem_a [DEPTH];
    logic [DATA_W-1:0] mem_b [DEPTH];

    // Stage 1: registered store reads
    logic              s1_valid_reg;
    mac_tag_t          s1_tag_reg;
    logic [DATA_W-1:0] s1_a_reg;
    logic [DATA_W-1:0] s1_b_reg;

    // Stage 2: product
    logic              s2_valid_reg;
    mac_tag_t          s2_tag_reg;
    logic [DATA_W-1:0] s2_prod_reg;
    logic [DATA_W-1:0] prod_next;

    // Stage 3: accumulator and output register
    logic [DATA_W-1:0] acc_reg;
    logic [DATA_W-1:0] sum_next;
    logic              out_valid_reg;
    logic [DATA_W-1:0] out_value_reg;
    logic [IDX_W-1:0]  out_row_reg;
    logic [IDX_W-1:0]  out_col_reg;
    logic              out_last_reg;

    // Freeze the whole pipeline while a result waits on the receiver
    assign pipe_en = !out_valid_reg || m_ready;

    // Store writes
    always_ff @(posedge aclk) begin
        if (cmd.wr_a) begin
            mem_a[wr_addr] <= wr_data;
        end
        if (cmd.wr_b) begin
            mem_b[wr_addr] <= wr_data;
        end
    end

    // Store reads
    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            s1_a_reg   <= mem_a[rd_a_addr];
            s1_b_reg   <= mem_b[rd_b_addr];
            s1_tag_reg <= cmd.tag;
        end
    end

    assign prod_next = s1_a_reg * s1_b_reg;
    assign sum_next  = s2_tag_reg.first ? s2_prod_reg : acc_reg + s2_prod_reg;

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            s2_prod_reg <= prod_next;
            s2_tag_reg  <= s1_tag_reg;
            if (s2_valid_reg) begin
                if (s2_tag_reg.last_term) begin
                    out_value_reg <= sum_next;
                    out_row_reg   <= s2_tag_reg.row;
                    out_col_reg   <= s2_tag_reg.col;
                    out_last_reg  <= s2_tag_reg.final_elem;
                end else begin
                    acc_reg <= sum_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            s1_valid_reg  <= cmd.issue;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg && s2_tag_reg.last_term;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_product_value = out_value_reg;
    assign m_row_index     = out_row_reg;
    assign m_col_index     = out_col_reg;
    assign m_last_result   = out_last_reg;

endmodule
`default_nettype wire

// ----- src/imm_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// imm_ctrl
// Dimension registers, load counter and the loop sequencer of the burst.
// ----------------------------------------------------------------------------
module imm_ctrl #(
    parameter int MAX_DIM = 8,
    parameter int AW      = 6
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          cfg_we,
    input  wire [1:0]                    cfg_index,
    input  wire [imm_pkg::DIM_W-1:0]     cfg_wdata,
    input  wire                          s_valid,
    output logic                         s_ready,
    input  wire                          pipe_en,
    output imm_pkg::imm_cmd_t            cmd,
    output logic [AW-1:0]                wr_addr,
    output logic [AW-1:0]                rd_a_addr,
    output logic [AW-1:0]                rd_b_addr
);
    import imm_pkg::*;

    typedef enum logic [1:0] {
        ST_LOAD = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    state_t           state_reg, state_next;
    logic [DIM_W-1:0] rows_a_reg, inner_dim_reg, cols_b_reg;
    logic [CNT_W-1:0] load_count_reg, load_count_next;
    logic [IDX_W-1:0] i_reg, i_next, j_reg, j_next, t_reg, t_next;
    logic [AW-1:0]    a_base_reg, a_base_next;
    logic [AW-1:0]    a_addr_reg, a_addr_next;
    logic [AW-1:0]    b_addr_reg, b_addr_next;

    logic [DIM_W-1:0] r_eff, k_eff, c_eff;
    logic [CNT_W-1:0] n_a, n_b, n_total, lc_eff, lc_inc, b_off;
    logic             accept, in_a;
    logic             t_last, j_last, i_last;

    assign r_eff = eff_dim(rows_a_reg, DIM_W'(MAX_DIM));
    assign k_eff = eff_dim(inner_dim_reg, DIM_W'(MAX_DIM));
    assign c_eff = eff_dim(cols_b_reg, DIM_W'(MAX_DIM));

    assign n_a     = CNT_W'(r_eff) * CNT_W'(k_eff);
    assign n_b     = CNT_W'(k_eff) * CNT_W'(c_eff);
    assign n_total = n_a + n_b;
    assign lc_eff  = (load_count_reg >= n_total) ? '0 : load_count_reg;
    assign lc_inc  = lc_eff + CNT_W'(1);
    assign b_off   = lc_eff - n_a;
    assign in_a    = lc_eff < n_a;

    assign s_ready = (state_reg == ST_LOAD);
    assign accept  = s_valid && s_ready;

    assign t_last = ({1'b0, t_reg} == k_eff - DIM_W'(1));
    assign j_last = ({1'b0, j_reg} == c_eff - DIM_W'(1));
    assign i_last = ({1'b0, i_reg} == r_eff - DIM_W'(1));

    // Commands to the datapath
    always_comb begin
        cmd                 = '0;
        cmd.wr_a            = accept && in_a;
        cmd.wr_b            = accept && !in_a;
        cmd.issue           = (state_reg == ST_RUN);
        cmd.tag.first       = (t_reg == '0);
        cmd.tag.last_term   = t_last;
        cmd.tag.row         = i_reg;
        cmd.tag.col         = j_reg;
        cmd.tag.final_elem  = t_last && j_last && i_last;
    end

    assign wr_addr   = in_a ? AW'(lc_eff) : AW'(b_off);
    assign rd_a_addr = a_addr_reg;
    assign rd_b_addr = b_addr_reg;

    // Next state: load elements, then walk rows, columns and terms
    always_comb begin
        state_next      = state_reg;
        load_count_next = load_count_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        t_next          = t_reg;
        a_base_next     = a_base_reg;
        a_addr_next     = a_addr_reg;
        b_addr_next     = b_addr_reg;
        case (state_reg)
            ST_LOAD: begin
                if (accept) begin
                    if (lc_inc == n_total) begin
                        load_count_next = '0;
                        state_next      = ST_RUN;
                        i_next          = '0;
                        j_next          = '0;
                        t_next          = '0;
                        a_base_next     = '0;
                        a_addr_next     = '0;
                        b_addr_next     = '0;
                    end else begin
                        load_count_next = lc_inc;
                    end
                end
                if (cfg_we && (cfg_index == REG_ROWS_A || cfg_index == REG_INNER_DIM
                               || cfg_index == REG_COLS_B)) begin
                    load_count_next = '0;
                end
            end
            ST_RUN: begin
                if (pipe_en) begin
                    if (!t_last) begin
                        t_next      = t_reg + IDX_W'(1);
                        a_addr_next = a_addr_reg + AW'(1);
                        b_addr_next = b_addr_reg + AW'(c_eff);
                    end else begin
                        t_next = '0;
                        if (j_last) begin
                            j_next      = '0;
                            i_next      = i_reg + IDX_W'(1);
                            a_base_next = a_base_reg + AW'(k_eff);
                            a_addr_next = a_base_reg + AW'(k_eff);
                            b_addr_next = '0;
                            if (i_last) begin
                                state_next = ST_LOAD;
                            end
                        end else begin
                            j_next      = j_reg + IDX_W'(1);
                            a_addr_next = a_base_reg;
                            b_addr_next = AW'({1'b0, j_reg} + DIM_W'(1));
                        end
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_LOAD;
            load_count_reg <= '0;
            rows_a_reg     <= DIM_W'(1);
            inner_dim_reg  <= DIM_W'(1);
            cols_b_reg     <= DIM_W'(1);
        end else begin
            state_reg      <= state_next;
            load_count_reg <= load_count_next;
            if (cfg_we) begin
                case (cfg_index)
                    REG_ROWS_A:    rows_a_reg    <= cfg_wdata;
                    REG_INNER_DIM: inner_dim_reg <= cfg_wdata;
                    REG_COLS_B:    cols_b_reg    <= cfg_wdata;
                    default:       ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        i_reg      <= i_next;
        j_reg      <= j_next;
        t_reg      <= t_next;
        a_base_reg <= a_base_next;
        a_addr_reg <= a_addr_next;
        b_addr_reg <= b_addr_next;
    end

endmodule
`default_nettype wire

// ----- src/integer_matrix_multiply.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// integer_matrix_multiply
// Loads A (rows_a x inner_dim) then B (inner_dim x cols_b), emits A*B.
// ----------------------------------------------------------------------------
// Usage:
//  - Set rows_a, inner_dim and cols_b through the cfg_we/cfg_index/cfg_wdata
//    write port while the block is idle. A 0 acts as 1 and values above
//    MAX_DIM act as MAX_DIM. A dimension write restarts a partial load.
//  - Send A row-major, then B row-major, one 32-bit signed element per
//    request on s_valid/s_ready.
//  - The request with the last B element starts the burst: s_ready drops and
//    one multiply-accumulate unit walks rows, columns and inner terms, one
//    term per cycle unless a stalled receiver freezes the pipeline.
//  - Results leave row-major on m_valid/m_ready with row, column and a last
//    flag.
//  - A stalled receiver freezes the MAC pipeline (store read, multiply,
//    accumulate) until the waiting result is taken; nothing is dropped.
//  - s_ready rises again once the last MAC is issued, so the next run loads
//    while the tail of the burst drains.
//  - Reset (aresetn, synchronous) sets all dimensions to 1, clears the load
//    counter and empties the pipeline. Stores are not cleared.
// ----------------------------------------------------------------------------
module integer_matrix_multiply #(
    parameter int MAX_DIM = 8
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    // Configuration write port
    input  wire                              cfg_we,
    input  wire [1:0]                        cfg_index,
    input  wire [imm_pkg::DIM_W-1:0]         cfg_wdata,
    // Element input
    input  wire                              s_valid,
    output logic                             s_ready,
    input  wire signed [imm_pkg::DATA_W-1:0] s_element,
    // Product output
    output logic                             m_valid,
    input  wire                              m_ready,
    output logic signed [imm_pkg::DATA_W-1:0] m_product_value,
    output logic [imm_pkg::IDX_W-1:0]        m_row_index,
    output logic [imm_pkg::IDX_W-1:0]        m_col_index,
    output logic                             m_last_result
);
    import imm_pkg::*;

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    imm_cmd_t      cmd;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_a_addr;
    logic [AW-1:0] rd_b_addr;
    logic          pipe_en;

    // Sequencer: dimensions, load counter, loop counters
    imm_ctrl #(
        .MAX_DIM (MAX_DIM),
        .AW      (AW)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .pipe_en   (pipe_en),
        .cmd       (cmd),
        .wr_addr   (wr_addr),
        .rd_a_addr (rd_a_addr),
        .rd_b_addr (rd_b_addr)
    );

    // Stores, MAC pipeline and output register
    imm_datapath #(
        .MAX_DIM (MAX_DIM),
        .AW      (AW)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .wr_addr         (wr_addr),
        .rd_a_addr       (rd_a_addr),
        .rd_b_addr       (rd_b_addr),
        .wr_data         (s_element),
        .pipe_en         (pipe_en),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_product_value (m_product_value),
        .m_row_index     (m_row_index),
        .m_col_index     (m_col_index),
        .m_last_result   (m_last_result)
    );

endmodule
`default_nettype wire

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for integer_matrix_multiply: loads A and B through the
// request channel, predicts every product element, and checks the result
// stream in order.
// ----------------------------------------------------------------------------
module tb_top;

    import imm_pkg::*;

    localparam int          STORE_DEPTH  = 64;
    localparam int          DRAIN_CYCLES = 40;       // load and MAC pipeline settle time
    localparam int          CYCLE_LIMIT  = 300000;
    localparam logic [1:0]  REG_UNUSED   = 2'd3;     // index past the register list

    // One product element as it leaves the block
    typedef struct {
        logic signed [DATA_W-1:0] value;
        logic [IDX_W-1:0]         row;
        logic [IDX_W-1:0]         col;
        logic                     last;
    } product_t;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     cfg_we = 1'b0;
    logic [1:0]               cfg_index = REG_ROWS_A;
    logic [DIM_W-1:0]         cfg_wdata = '0;
    logic                     s_valid = 1'b0;
    wire                      s_ready;
    logic signed [DATA_W-1:0] s_element = '0;
    wire                      m_valid;
    logic                     m_ready = 1'b0;
    wire signed [DATA_W-1:0]  m_product_value;
    wire [IDX_W-1:0]          m_row_index;
    wire [IDX_W-1:0]          m_col_index;
    wire                      m_last_result;

    // Shadow of the block: dimension registers, both stores, load counter
    logic [DIM_W-1:0]  rows_reg  = 4'd1;
    logic [DIM_W-1:0]  inner_reg = 4'd1;
    logic [DIM_W-1:0]  cols_reg  = 4'd1;
    logic [DATA_W-1:0] a_mem [STORE_DEPTH];
    logic [DATA_W-1:0] b_mem [STORE_DEPTH];
    int                load_cnt = 0;

    product_t pending_products[$];
    product_t head_product;
    int       error_count = 0;
    int       cycle_count = 0;
    int       send_idle_pct = 0;
    int       recv_stall_pct = 0;

    integer_matrix_multiply #(.MAX_DIM(8)) DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_element       (s_element),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_product_value (m_product_value),
        .m_row_index     (m_row_index),
        .m_col_index     (m_col_index),
        .m_last_result   (m_last_result)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Hard stop in case the block hangs
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Receiver back-pressure, one fresh draw per cycle
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Compare every accepted result with the oldest predicted product
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_products.size() == 0) begin
                $error("unexpected product: value %0d row %0d col %0d last %0b",
                       m_product_value, m_row_index, m_col_index, m_last_result);
                error_count++;
            end else begin
                head_product = pending_products.pop_front();
                if (m_product_value !== head_product.value) begin
                    $error("product_value: expected %0d, got %0d",
                           head_product.value, m_product_value);
                    error_count++;
                end
                if (m_row_index !== head_product.row) begin
                    $error("row_index: expected %0d, got %0d",
                           head_product.row, m_row_index);
                    error_count++;
                end
                if (m_col_index !== head_product.col) begin
                    $error("col_index: expected %0d, got %0d",
                           head_product.col, m_col_index);
                    error_count++;
                end
                if (m_last_result !== head_product.last) begin
                    $error("last_result: expected %0b, got %0b",
                           head_product.last, m_last_result);
                    error_count++;
                end
            end
        end
    end

    // Map a written dimension to the one in use: 0 acts as 1, above 8 acts as 8
    function automatic int dim_in_use(input logic [DIM_W-1:0] v);
        if (v == 0) return 1;
        if (v > 8) return 8;
        return int'(v);
    endfunction

    // Take one accepted element into the shadow stores; on the last B element
    // queue the whole product in row-major order.
    task automatic absorb_element(input logic [DATA_W-1:0] elem);
        int                r;
        int                k;
        int                c;
        int                n_a;
        int                n_b;
        logic [DATA_W-1:0] acc;
        logic [DATA_W-1:0] term;
        product_t          p;
        r = dim_in_use(rows_reg);
        k = dim_in_use(inner_reg);
        c = dim_in_use(cols_reg);
        n_a = r * k;
        n_b = k * c;
        if (load_cnt >= n_a + n_b) load_cnt = 0;
        if (load_cnt < n_a) begin
            a_mem[load_cnt] = elem;
            load_cnt++;
            return;
        end
        b_mem[load_cnt - n_a] = elem;
        load_cnt++;
        if (load_cnt < n_a + n_b) return;
        for (int i = 0; i < r; i++) begin
            for (int j = 0; j < c; j++) begin
                acc = '0;
                for (int t = 0; t < k; t++) begin
                    term = a_mem[i * k + t] * b_mem[t * c + j];   // low 32 bits only
                    acc = acc + term;
                end
                p.value = acc;
                p.row   = i[IDX_W-1:0];
                p.col   = j[IDX_W-1:0];
                p.last  = (i == r - 1) && (j == c - 1);
                pending_products.push_back(p);
            end
        end
        load_cnt = 0;
    endtask

    // Present one request and hold it until the block takes it
    task automatic send_element(input logic [DATA_W-1:0] elem);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_element <= elem;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        absorb_element(elem);
    endtask

    // Drop the request line, wait for every predicted product, then let the
    // pipeline settle before touching the registers
    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_products.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // One register write; any valid index abandons a partial load
    task automatic write_reg(input logic [1:0] idx, input logic [DIM_W-1:0] value);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_ROWS_A: begin
                rows_reg = value;
                load_cnt = 0;
            end
            REG_INNER_DIM: begin
                inner_reg = value;
                load_cnt = 0;
            end
            REG_COLS_B: begin
                cols_reg = value;
                load_cnt = 0;
            end
            default: begin
            end
        endcase
    endtask

    function automatic logic [DATA_W-1:0] rand_element();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0;
            3: return 32'hffff_ffff;
            4: return $urandom_range(0, 15) - 8;
            default: return $urandom;
        endcase
    endfunction

    // Mostly small sizes; 0 and 9..15 exercise the clamp
    function automatic logic [DIM_W-1:0] rand_dim();
        case ($urandom_range(0, 15))
            0: return 4'd0;
            1: return DIM_W'($urandom_range(9, 15));
            2: return 4'd8;
            default: return DIM_W'($urandom_range(1, 4));
        endcase
    endfunction

    // Default 1x1x1 after reset: most negative times -1 wraps to itself
    task automatic test_default_dims();
        send_element(32'h8000_0000);
        send_element(32'hffff_ffff);
    endtask

    // rows and cols written as 0 act as 1, inner written as 15 acts as 8
    task automatic test_clamped_dims();
        wait_idle();
        write_reg(REG_ROWS_A, 4'd0);
        write_reg(REG_INNER_DIM, 4'd15);
        write_reg(REG_COLS_B, 4'd0);
        send_element(32'h7fff_ffff);
        send_element(32'h8000_0000);
        send_element(32'hffff_ffff);
        send_element(32'h0);
        send_element(32'h0000_0001);
        send_element(32'haaaa_aaaa);
        send_element(32'h5555_5555);
        send_element(32'h7fff_ffff);
        send_element(32'h7fff_ffff);
        send_element(32'h8000_0000);
        send_element(32'h8000_0000);
        send_element(32'hffff_ffff);
        send_element(32'h5555_5555);
        send_element(32'haaaa_aaaa);
        send_element(32'h1234_5678);
        send_element(32'hffff_ffff);
    endtask

    // A write past the register list keeps a partial load; a real write drops it
    task automatic test_abandoned_load();
        wait_idle();
        write_reg(REG_ROWS_A, 4'd1);
        write_reg(REG_INNER_DIM, 4'd1);
        write_reg(REG_COLS_B, 4'd2);
        send_element(32'h0000_0003);
        send_element(32'hffff_fffb);
        wait_idle();
        write_reg(REG_UNUSED, 4'hf);
        send_element(32'h7fff_ffff);
        send_element(32'h0000_0007);
        send_element(32'h8000_0000);
        wait_idle();
        write_reg(REG_COLS_B, 4'd2);
        send_element(32'hffff_fff9);
        send_element(32'h0000_0011);
        send_element(32'h8000_0001);
    endtask

    // Well-formed runs with random content and sizes; now and then a run is cut
    // short and abandoned by a register write
    task automatic test_random_runs(input int n_items, input int idle_pct,
                                    input int stall_pct);
        int sent;
        int run_len;
        int cut;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 99) < 60) begin
                wait_idle();
                write_reg(REG_ROWS_A, rand_dim());
                write_reg(REG_INNER_DIM, rand_dim());
                write_reg(REG_COLS_B, rand_dim());
            end
            run_len = dim_in_use(rows_reg) * dim_in_use(inner_reg)
                    + dim_in_use(inner_reg) * dim_in_use(cols_reg);
            cut = run_len;
            if (run_len > 1 && $urandom_range(0, 99) < 10)
                cut = $urandom_range(1, run_len - 1);
            for (int i = 0; i < cut; i++) send_element(rand_element());
            sent += cut;
            if (cut < run_len) begin
                wait_idle();
                write_reg(REG_ROWS_A, rows_reg);
            end
        end
    endtask

    initial begin
        // Hold reset, then release on a clock edge
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_default_dims();
        test_clamped_dims();
        test_abandoned_load();
        test_random_runs(80, 0, 0);
        test_random_runs(80, 80, 0);
        test_random_runs(80, 0, 80);
        test_random_runs(80, 11, 11);

        wait_idle();
        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
src/imm_pkg.sv
src/imm_datapath.sv
src/imm_ctrl.sv
src/integer_matrix_multiply.sv
dv/tb_top.sv
